[rtl/tsrg_pkg.sv]
`default_nettype none
package tsrg_pkg;

	// reply kinds
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_SYNACK   = 2'd1,
		KIND_RST      = 2'd2,
		KIND_REDIRECT = 2'd3
	} reply_kind_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSS          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_SUM     = 3'd4;
	localparam int CFG_DATA_W = 16;

	// reset values
	localparam logic [15:0] RST_WINDOW_SIZE  = 16'd5000;
	localparam logic [15:0] RST_MSS          = 16'd1440;
	localparam logic [3:0]  RST_WINDOW_SCALE = 4'd7;

	// protocol constants
	localparam logic [15:0] PROTO_TCP     = 16'd6;
	localparam logic [15:0] IP_TTL        = 16'd64;
	localparam logic [15:0] IP_IDENT      = 16'd10;
	// version/IHL/TOS word + identification + DF word + TTL/protocol word
	localparam logic [15:0] IP_FIXED_SUM  = 16'h4500 + IP_IDENT + 16'h4000
		+ ((IP_TTL << 8) | PROTO_TCP);
	localparam logic [15:0] TCP_HDR_BASE  = 16'd20;
	localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
	localparam logic [15:0] TCP_SYNACK_LEN = 16'd28;

	// TCP flags
	localparam logic [7:0] TF_FIN = 8'h01;
	localparam logic [7:0] TF_SYN = 8'h02;
	localparam logic [7:0] TF_RST = 8'h04;
	localparam logic [7:0] TF_ACK = 8'h10;

	// option words
	localparam logic [15:0] OPT_MSS_KIND = 16'h0204;
	localparam logic [15:0] OPT_NOP_WS   = 16'h0103;
	localparam logic [15:0] OPT_WS_KIND  = 16'h0300;

	localparam int TCP_LEN_W  = 13;
	localparam int ACC_W      = 23;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

	// live configuration
	typedef struct packed {
		logic [15:0] window_size;
		logic [15:0] max_segment_size;
		logic [3:0]  window_scale;
		logic [11:0] body_length;
		logic [15:0] body_sum;
	} cfg_t;

	// classified item between front and back
	typedef struct packed {
		reply_kind_t           kind;
		logic [31:0]           src_addr;
		logic [31:0]           dst_addr;
		logic [15:0]           src_port;
		logic [15:0]           dst_port;
		logic [31:0]           seq;
		logic [31:0]           ack;
		logic [15:0]           tot_len;
		logic [TCP_LEN_W-1:0]  tcp_len;
	} reply_item_t;

	// fold a ones-complement accumulator and complement it
	function automatic logic [15:0] csum_finish(input logic [ACC_W-1:0] acc);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = {1'b0, acc[15:0]} + 17'(acc[ACC_W-1:16]);
		f2 = {1'b0, f1[15:0]} + 17'(f1[16]);
		return ~f2[15:0];
	endfunction

endpackage
`default_nettype wire

[rtl/tcp_spoof_reply_generator.sv]
// Forged TCP reply generator.
// Input: one parsed IPv4/TCP header per item, taken at a rising edge with
// start high and busy low. Every item gives exactly one result, including
// items that need no reply (reply_kind zero, all other fields zero).
// Output: each result is shown for one cycle with done high; the receiver
// cannot hold it off, so the back end never waits.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// at once (window, MSS, window scale, body length, body sum); unknown
// indexes are dropped. Write only while no item is in flight.
// Pipeline: an accepted item passes the front register, the item queue,
// the partial-sum stage and the fold stage; done rises with the result
// registered in the fold stage.
// Throughput: one item per cycle; the back end drains the queue every
// cycle, so it never holds more than one item and busy stays low.
// Reset: arst_n clears the pipeline and queue and loads the register
// defaults (window 5000, MSS 1440, scale 7, body length and sum 0).
`default_nettype none
module tcp_spoof_reply_generator import tsrg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [31:0]           source_address,
	input  wire logic [31:0]           dest_address,
	input  wire logic [15:0]           source_port,
	input  wire logic [15:0]           dest_port,
	input  wire logic [31:0]           sequence_in,
	input  wire logic [31:0]           acknowledge_in,
	input  wire logic                  syn_flag,
	input  wire logic                  fin_flag,
	input  wire logic                  ack_flag,
	input  wire logic [15:0]           ip_total_length,
	input  wire logic [3:0]            ip_header_words,
	input  wire logic [3:0]            tcp_header_words,
	output logic                       done,
	output logic [1:0]                 reply_kind,
	output logic [31:0]                reply_source_address,
	output logic [31:0]                reply_dest_address,
	output logic [15:0]                reply_source_port,
	output logic [15:0]                reply_dest_port,
	output logic [31:0]                reply_sequence,
	output logic [31:0]                reply_acknowledge,
	output logic [15:0]                reply_total_length,
	output logic [15:0]                reply_ip_checksum,
	output logic [15:0]                reply_tcp_checksum
);

	cfg_t        cfg_q;
	logic        take;
	logic        push;
	reply_item_t front_item;
	reply_item_t head;
	logic        not_empty;
	logic        almost_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size      <= RST_WINDOW_SIZE;
			cfg_q.max_segment_size <= RST_MSS;
			cfg_q.window_scale     <= RST_WINDOW_SCALE;
			cfg_q.body_length      <= '0;
			cfg_q.body_sum         <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WINDOW_SIZE:  cfg_q.window_size      <= cfg_data;
				CFG_MSS:          cfg_q.max_segment_size <= cfg_data;
				CFG_WINDOW_SCALE: cfg_q.window_scale     <= cfg_data[3:0];
				CFG_BODY_LENGTH:  cfg_q.body_length      <= cfg_data[11:0];
				CFG_BODY_SUM:     cfg_q.body_sum         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = almost_full;
	assign take = start && !busy;

	tsrg_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.source_address   (source_address),
		.dest_address     (dest_address),
		.source_port      (source_port),
		.dest_port        (dest_port),
		.sequence_in      (sequence_in),
		.acknowledge_in   (acknowledge_in),
		.syn_flag         (syn_flag),
		.fin_flag         (fin_flag),
		.ack_flag         (ack_flag),
		.ip_total_length  (ip_total_length),
		.ip_header_words  (ip_header_words),
		.tcp_header_words (tcp_header_words),
		.cfg              (cfg_q),
		.push             (push),
		.item             (front_item)
	);

	tsrg_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_item   (front_item),
		.pop         (not_empty),
		.head        (head),
		.not_empty   (not_empty),
		.almost_full (almost_full)
	);

	tsrg_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.valid                (not_empty),
		.item                 (head),
		.cfg                  (cfg_q),
		.done                 (done),
		.reply_kind           (reply_kind),
		.reply_source_address (reply_source_address),
		.reply_dest_address   (reply_dest_address),
		.reply_source_port    (reply_source_port),
		.reply_dest_port      (reply_dest_port),
		.reply_sequence       (reply_sequence),
		.reply_acknowledge    (reply_acknowledge),
		.reply_total_length   (reply_total_length),
		.reply_ip_checksum    (reply_ip_checksum),
		.reply_tcp_checksum   (reply_tcp_checksum)
	);

endmodule
`default_nettype wire

[rtl/tsrg_front.sv]
`default_nettype none
module tsrg_front import tsrg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [31:0] source_address,
	input  wire logic [31:0] dest_address,
	input  wire logic [15:0] source_port,
	input  wire logic [15:0] dest_port,
	input  wire logic [31:0] sequence_in,
	input  wire logic [31:0] acknowledge_in,
	input  wire logic        syn_flag,
	input  wire logic        fin_flag,
	input  wire logic        ack_flag,
	input  wire logic [15:0] ip_total_length,
	input  wire logic [3:0]  ip_header_words,
	input  wire logic [3:0]  tcp_header_words,
	input  wire cfg_t        cfg,
	output logic             push,
	output reply_item_t      item
);

	logic [6:0]     hdr_bytes;
	logic [15:0]    payload;
	reply_item_t    cls;
	logic           push_s1;
	reply_item_t    item_s1;

	// classify and work out sequence numbers and lengths
	always_comb begin
		hdr_bytes = {5'(ip_header_words) + 5'(tcp_header_words), 2'b00};
		payload   = ip_total_length - 16'(hdr_bytes);
		cls.src_addr = dest_address;
		cls.dst_addr = source_address;
		cls.src_port = dest_port;
		cls.dst_port = source_port;
		cls.seq      = ack_flag ? acknowledge_in : sequence_in;
		cls.ack      = sequence_in + 32'(syn_flag) + 32'(fin_flag);
		if (syn_flag) begin
			cls.kind    = KIND_SYNACK;
			cls.tcp_len = TCP_LEN_W'(TCP_SYNACK_LEN);
		end else if (fin_flag) begin
			cls.kind    = KIND_RST;
			cls.tcp_len = TCP_LEN_W'(TCP_HDR_BASE);
		end else if (ack_flag && (ip_total_length > 16'(hdr_bytes))) begin
			cls.kind    = KIND_REDIRECT;
			cls.tcp_len = TCP_LEN_W'(TCP_HDR_BASE) + TCP_LEN_W'(cfg.body_length);
			cls.ack     = sequence_in + 32'(payload);
		end else begin
			cls.kind    = KIND_NONE;
			cls.tcp_len = '0;
		end
		cls.tot_len = IP_HDR_BYTES + 16'(cls.tcp_len);
	end

	// front register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
		end else begin
			push_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

	assign push = push_s1;
	assign item = item_s1;

endmodule
`default_nettype wire

[rtl/tsrg_queue.sv]
`default_nettype none
module tsrg_queue import tsrg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire reply_item_t push_item,
	input  wire logic        pop,
	output reply_item_t      head,
	output logic             not_empty,
	output logic             almost_full
);

	reply_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_pop;

	assign do_pop      = pop && (count_q != '0);
	assign not_empty   = (count_q != '0);
	assign almost_full = (count_q >= (QPTR_W+1)'(QUEUE_DEPTH - 1));
	assign head        = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

[rtl/tsrg_back.sv]
`default_nettype none
module tsrg_back import tsrg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	input  wire reply_item_t item,
	input  wire cfg_t        cfg,
	output logic             done,
	output logic [1:0]       reply_kind,
	output logic [31:0]      reply_source_address,
	output logic [31:0]      reply_dest_address,
	output logic [15:0]      reply_source_port,
	output logic [15:0]      reply_dest_port,
	output logic [31:0]      reply_sequence,
	output logic [31:0]      reply_acknowledge,
	output logic [15:0]      reply_total_length,
	output logic [15:0]      reply_ip_checksum,
	output logic [15:0]      reply_tcp_checksum
);

	logic [15:0]      hdr_word;
	logic [16:0]      opt_a;
	logic [15:0]      opt_b;
	logic [ACC_W-1:0] ip_acc;
	logic [ACC_W-1:0] tcp_a;
	logic [ACC_W-1:0] tcp_b;

	logic             valid_s1;
	reply_item_t      item_s1;
	logic [ACC_W-1:0] ip_acc_s1;
	logic [ACC_W-1:0] tcp_a_s1;
	logic [ACC_W-1:0] tcp_b_s1;

	logic             valid_s2;
	reply_item_t      item_s2;
	logic [15:0]      ip_ck_s2;
	logic [15:0]      tcp_ck_s2;
	logic             hit;

	// header word, options and partial sums
	always_comb begin
		opt_a = '0;
		opt_b = '0;
		case (item.kind)
			KIND_SYNACK: begin
				hdr_word = {4'd7, 4'd0, TF_SYN | TF_ACK};
				// MSS word plus value can carry out of 16 bits
				opt_a    = 17'(OPT_MSS_KIND) + 17'(cfg.max_segment_size);
				opt_b    = OPT_NOP_WS + (OPT_WS_KIND | 16'(cfg.window_scale));
			end
			KIND_RST: begin
				hdr_word = {4'd5, 4'd0, TF_ACK | TF_RST};
			end
			KIND_REDIRECT: begin
				hdr_word = {4'd5, 4'd0, TF_ACK | TF_FIN};
				opt_a    = 17'(cfg.body_sum);
			end
			default: begin
				hdr_word = '0;
			end
		endcase
		ip_acc = ACC_W'(IP_FIXED_SUM) + ACC_W'(item.tot_len)
			+ ACC_W'(item.src_addr[31:16]) + ACC_W'(item.src_addr[15:0])
			+ ACC_W'(item.dst_addr[31:16]) + ACC_W'(item.dst_addr[15:0]);
		tcp_a = ACC_W'(item.src_addr[31:16]) + ACC_W'(item.src_addr[15:0])
			+ ACC_W'(item.dst_addr[31:16]) + ACC_W'(item.dst_addr[15:0])
			+ ACC_W'(PROTO_TCP) + ACC_W'(item.tcp_len)
			+ ACC_W'(item.src_port) + ACC_W'(item.dst_port);
		tcp_b = ACC_W'(item.seq[31:16]) + ACC_W'(item.seq[15:0])
			+ ACC_W'(item.ack[31:16]) + ACC_W'(item.ack[15:0])
			+ ACC_W'(hdr_word) + ACC_W'(cfg.window_size)
			+ ACC_W'(opt_a) + ACC_W'(opt_b);
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage one: partial sums; stage two: fold and complement
	always_ff @(posedge clk) begin
		if (valid) begin
			item_s1   <= item;
			ip_acc_s1 <= ip_acc;
			tcp_a_s1  <= tcp_a;
			tcp_b_s1  <= tcp_b;
		end
		if (valid_s1) begin
			item_s2   <= item_s1;
			ip_ck_s2  <= csum_finish(ip_acc_s1);
			tcp_ck_s2 <= csum_finish(tcp_a_s1 + tcp_b_s1);
		end
	end

	// no reply: every field reads zero
	assign hit                  = (item_s2.kind != KIND_NONE);
	assign done                 = valid_s2;
	assign reply_kind           = item_s2.kind;
	assign reply_source_address = hit ? item_s2.src_addr : '0;
	assign reply_dest_address   = hit ? item_s2.dst_addr : '0;
	assign reply_source_port    = hit ? item_s2.src_port : '0;
	assign reply_dest_port      = hit ? item_s2.dst_port : '0;
	assign reply_sequence       = hit ? item_s2.seq : '0;
	assign reply_acknowledge    = hit ? item_s2.ack : '0;
	assign reply_total_length   = hit ? item_s2.tot_len : '0;
	assign reply_ip_checksum    = hit ? ip_ck_s2 : '0;
	assign reply_tcp_checksum   = hit ? tcp_ck_s2 : '0;

endmodule
`default_nettype wire
